### design/pmw_pkg.sv
// pmw_pkg: shared types and codes for the priority mutex wait queue.
// No dependencies; used by every module of the block.
package pmw_pkg;

  localparam int TID_W  = 8;
  localparam int NICE_W = 7;

  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_LOCK   = 2'd1;
  localparam logic [1:0] ACT_UNLOCK = 2'd2;

  localparam logic [2:0] STAT_OK            = 3'd0;
  localparam logic [2:0] STAT_QUEUED        = 3'd1;
  localparam logic [2:0] STAT_NOT_INIT      = 3'd2;
  localparam logic [2:0] STAT_ALREADY_OWNER = 3'd3;
  localparam logic [2:0] STAT_NOT_OWNER     = 3'd4;
  localparam logic [2:0] STAT_ALREADY_INIT  = 3'd5;
  localparam logic [2:0] STAT_FULL          = 3'd6;

  typedef struct packed {
    logic [1:0]        action;
    logic [TID_W-1:0]  thread_id;
    logic [NICE_W-1:0] nice_value;
  } pmw_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             woken_valid;
    logic [TID_W-1:0] woken_thread;
  } pmw_out_t;

  // Token that walks the slot chain: a lock looks for the first free slot,
  // an unlock carries the best waiter seen so far.
  typedef struct packed {
    logic              active;
    logic              is_lock;
    logic [TID_W-1:0]  tid;
    logic [NICE_W-1:0] nice;
    logic              done;
    logic [NICE_W-1:0] best_nice;
    logic [TID_W-1:0]  best_thread;
  } pmw_tok_t;

endpackage

### design/pmw_cell.sv
// pmw_cell: one wait slot plus a registered stage of the token chain.
// Depends on pmw_pkg.
module pmw_cell #(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear_all,
  input  logic             clear_en,
  input  logic [IW-1:0]    clear_idx,
  input  pmw_pkg::pmw_tok_t tok_i,
  input  logic [IW-1:0]    idx_i,
  output pmw_pkg::pmw_tok_t tok_o,
  output logic [IW-1:0]    idx_o
);

  logic                          valid_r;
  logic [pmw_pkg::TID_W-1:0]     thread_r;
  logic [pmw_pkg::NICE_W-1:0]    nice_r;
  pmw_pkg::pmw_tok_t             tok_r, tok_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic                          wr;

  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    wr      = 1'b0;
    if (tok_i.active) begin
      if (tok_i.is_lock) begin
        // first free slot takes the waiter
        if (!tok_i.done && !valid_r) begin
          wr           = 1'b1;
          tok_nxt.done = 1'b1;
        end
      end else if (valid_r && (!tok_i.done || nice_r < tok_i.best_nice)) begin
        // strict less-than keeps the lowest slot on ties
        tok_nxt.done        = 1'b1;
        tok_nxt.best_nice   = nice_r;
        tok_nxt.best_thread = thread_r;
        idx_nxt             = IW'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear_all) begin
      valid_r <= 1'b0;
    end else if (wr) begin
      valid_r <= 1'b1;
    end else if (clear_en && clear_idx == IW'(IDX)) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      thread_r <= tok_i.tid;
      nice_r   <= tok_i.nice;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

### design/priority_mutex_waitqueue.sv
// priority_mutex_waitqueue: top level of the priority mutex with wait slots.
// Depends on pmw_pkg and pmw_cell.
//
// One transaction is accepted when start is high and busy is low; each one
// yields exactly one result, shown for one cycle with out_valid high. The
// receiver cannot stall, so results are never held back. Init, error cases
// and a lock on a free mutex are answered directly: the result shows in the
// cycle after acceptance and the next transaction can be accepted in that
// same cycle. A lock that must wait and an unlock by the owner send a token
// through the chain of WAIT_SLOTS slot cells, one cell per cycle; busy
// stays high while the token is in the chain and the result shows in the
// cycle busy falls. The lock waiter picks the first free slot; the unlock
// search picks the lowest nice value, lowest slot on ties, and hands
// ownership straight to that thread.
module priority_mutex_waitqueue #(
  parameter int WAIT_SLOTS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pmw_pkg::pmw_in_t  in_item,
  output logic              out_valid,
  output pmw_pkg::pmw_out_t out_item
);

  localparam int IW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int CW = $clog2(WAIT_SLOTS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                      state_r, state_nxt;
  logic                      init_r, init_nxt;
  logic                      held_r, held_nxt;
  logic [pmw_pkg::TID_W-1:0] owner_r, owner_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  pmw_pkg::pmw_out_t         out_item_r, out_item_nxt;

  logic                      accept;
  logic                      launch;
  logic                      clear_all;
  logic                      clear_en;

  pmw_pkg::pmw_tok_t         tok_w [WAIT_SLOTS+1];
  logic [IW-1:0]             idx_w [WAIT_SLOTS+1];
  pmw_pkg::pmw_tok_t         tail;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_SCAN);
  assign tail   = tok_w[WAIT_SLOTS];

  // request decode and the finish of a chain pass
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    held_nxt      = held_r;
    owner_nxt     = owner_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    launch        = 1'b0;
    clear_all     = 1'b0;
    clear_en      = 1'b0;

    if (accept) begin
      out_valid_nxt = 1'b1;
      if (in_item.action == pmw_pkg::ACT_INIT) begin
        if (init_r) begin
          out_item_nxt.status = pmw_pkg::STAT_ALREADY_INIT;
        end else begin
          init_nxt  = 1'b1;
          held_nxt  = 1'b0;
          owner_nxt = '0;
          cnt_nxt   = '0;
          clear_all = 1'b1;
          out_item_nxt.status = pmw_pkg::STAT_OK;
        end
      end else if (!init_r) begin
        out_item_nxt.status = pmw_pkg::STAT_NOT_INIT;
      end else if (in_item.action == pmw_pkg::ACT_LOCK) begin
        if (!held_r) begin
          held_nxt  = 1'b1;
          owner_nxt = in_item.thread_id;
          out_item_nxt.status = pmw_pkg::STAT_OK;
        end else if (owner_r == in_item.thread_id) begin
          out_item_nxt.status = pmw_pkg::STAT_ALREADY_OWNER;
        end else if (cnt_r == CW'(WAIT_SLOTS)) begin
          out_item_nxt.status = pmw_pkg::STAT_FULL;
        end else begin
          // park the caller: walk the chain for a free slot
          launch        = 1'b1;
          out_valid_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end else if (in_item.action == pmw_pkg::ACT_UNLOCK) begin
        if (!held_r || owner_r != in_item.thread_id) begin
          out_item_nxt.status = pmw_pkg::STAT_NOT_OWNER;
        end else begin
          // owner releases: search the chain for the best waiter
          launch        = 1'b1;
          out_valid_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end else begin
        out_item_nxt.status = pmw_pkg::STAT_NOT_OWNER;
      end
    end else if (state_r == S_SCAN && tail.active) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      if (tail.is_lock) begin
        cnt_nxt = cnt_r + CW'(1);
        out_item_nxt.status = pmw_pkg::STAT_QUEUED;
      end else begin
        out_item_nxt.status = pmw_pkg::STAT_OK;
        if (tail.done) begin
          // hand-off: held stays set, winner's slot is freed
          clear_en  = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
          owner_nxt = tail.best_thread;
          out_item_nxt.woken_valid  = 1'b1;
          out_item_nxt.woken_thread = tail.best_thread;
        end else begin
          held_nxt  = 1'b0;
          owner_nxt = '0;
        end
      end
    end
  end

  // token entering the head of the chain
  always_comb begin
    tok_w[0]             = '0;
    tok_w[0].active      = launch;
    tok_w[0].is_lock     = (in_item.action == pmw_pkg::ACT_LOCK);
    tok_w[0].tid         = in_item.thread_id;
    tok_w[0].nice        = in_item.nice_value;
    idx_w[0]             = '0;
  end

  for (genvar g = 0; g < WAIT_SLOTS; g++) begin : g_cell
    pmw_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear_all (clear_all),
      .clear_en  (clear_en),
      .clear_idx (idx_w[WAIT_SLOTS]),
      .tok_i     (tok_w[g]),
      .idx_i     (idx_w[g]),
      .tok_o     (tok_w[g+1]),
      .idx_o     (idx_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= 1'b0;
      held_r      <= 1'b0;
      owner_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      held_r      <= held_nxt;
      owner_r     <= owner_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/pmw_checker.sv
// pmw_checker: port-level assertions for priority_mutex_waitqueue.
// Depends on pmw_pkg; bound to the top level at the end of this file.
module pmw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input pmw_pkg::pmw_in_t  in_item,
  input logic              out_valid,
  input pmw_pkg::pmw_out_t out_item
);

  // an accepted transaction either answers at once or starts a chain pass
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction neither answered nor went busy");

  // a chain pass always ends with its result
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  // no result while a chain pass is still running
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result shown while busy");

  // a wake-up only comes with a successful unlock
  a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.woken_valid) |-> (out_item.status == pmw_pkg::STAT_OK))
    else $error("woken thread reported with a non-ok status");

  // a result without a preceding accepted transaction is invented
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(busy)) |-> $past(start))
    else $error("result without a transaction");

endmodule

bind priority_mutex_waitqueue pmw_checker u_pmw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

### tb/sv/priority_mutex_waitqueue_test.sv
// priority_mutex_waitqueue_test: self-checking testbench for the priority mutex wait queue.
// Depends on pmw_pkg and the priority_mutex_waitqueue RTL; needs no other files.
// Runs directed transactions, then random lock/unlock traffic, each checked against a scoreboard.
module priority_mutex_waitqueue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TID_W  = pmw_pkg::TID_W;
  localparam int NICE_W = pmw_pkg::NICE_W;

  localparam int WAIT_SLOTS = 7;
  // The action field is two bits wide, so code 3 exists but means nothing.
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int TOTAL_ITEMS = 1950;
  localparam int STALL_LIMIT = 600;    // idle cycles before the run is declared hung

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  pmw_pkg::pmw_in_t  in_item = '0;
  logic              busy;
  logic              out_valid;
  pmw_pkg::pmw_out_t out_item;

  priority_mutex_waitqueue #(.WAIT_SLOTS(WAIT_SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mutex shadow state. It is updated in acceptance order, one call per accepted
  // transaction, so its results line up with what the block emits.
  // ---------------------------------------------------------------------------
  logic              mx_init;
  logic              mx_held;
  logic [TID_W-1:0]  mx_owner;
  logic              wq_valid  [WAIT_SLOTS];
  logic [TID_W-1:0]  wq_thread [WAIT_SLOTS];
  logic [NICE_W-1:0] wq_nice   [WAIT_SLOTS];

  pmw_pkg::pmw_out_t expected_results[$];
  int                fail_count = 0;
  int                issued = 0;
  bit                tight = 1'b0;           // back-to-back transactions, no gaps

  // Works out one result and advances the shadow state.
  function automatic pmw_pkg::pmw_out_t mutex_predict(pmw_pkg::pmw_in_t req);
    pmw_pkg::pmw_out_t res;
    int                slot;
    res  = '0;
    slot = -1;
    res.status = pmw_pkg::STAT_OK;
    if (req.action == pmw_pkg::ACT_INIT) begin
      if (mx_init) begin
        res.status = pmw_pkg::STAT_ALREADY_INIT;
      end else begin
        mx_init  = 1'b1;
        mx_held  = 1'b0;
        mx_owner = '0;
        for (int i = 0; i < WAIT_SLOTS; i++) wq_valid[i] = 1'b0;
      end
    end else if (!mx_init) begin
      res.status = pmw_pkg::STAT_NOT_INIT;
    end else if (req.action == pmw_pkg::ACT_LOCK) begin
      if (!mx_held) begin
        mx_held  = 1'b1;
        mx_owner = req.thread_id;
      end else if (mx_owner == req.thread_id) begin
        res.status = pmw_pkg::STAT_ALREADY_OWNER;
      end else begin
        // first free slot takes the waiter
        for (int i = 0; i < WAIT_SLOTS; i++)
          if (!wq_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          res.status = pmw_pkg::STAT_FULL;
        end else begin
          wq_valid[slot]  = 1'b1;
          wq_thread[slot] = req.thread_id;
          wq_nice[slot]   = req.nice_value;
          res.status      = pmw_pkg::STAT_QUEUED;
        end
      end
    end else if (req.action == pmw_pkg::ACT_UNLOCK) begin
      if (!mx_held || mx_owner != req.thread_id) begin
        res.status = pmw_pkg::STAT_NOT_OWNER;
      end else begin
        // lowest nice wins, strict compare keeps the lowest slot on ties
        for (int i = 0; i < WAIT_SLOTS; i++)
          if (wq_valid[i] && (slot < 0 || wq_nice[i] < wq_nice[slot])) slot = i;
        if (slot >= 0) begin
          wq_valid[slot]   = 1'b0;
          mx_owner         = wq_thread[slot];
          res.woken_valid  = 1'b1;
          res.woken_thread = mx_owner;
        end else begin
          mx_held  = 1'b0;
          mx_owner = '0;
        end
      end
    end else begin
      res.status = pmw_pkg::STAT_NOT_OWNER;
    end
    return res;
  endfunction

  function automatic pmw_pkg::pmw_in_t make_req(logic [1:0] act, logic [TID_W-1:0] tid,
                                                logic [NICE_W-1:0] nice);
    pmw_pkg::pmw_in_t r;
    r.action     = act;
    r.thread_id  = tid;
    r.nice_value = nice;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. start is left high after acceptance so that a zero-gap
  // follow-up never lowers and raises it in the same step; a gap lowers it.
  // ---------------------------------------------------------------------------
  task automatic issue(input pmw_pkg::pmw_in_t req);
    int gap;
    gap = tight ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    expected_results.push_back(mutex_predict(req));
    issued++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe pops the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    pmw_pkg::pmw_out_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("result transaction with nothing outstanding: status %0d", out_item.status);
      end else begin
        exp_res = expected_results.pop_front();
        compare_field("status", 8'(exp_res.status), 8'(out_item.status));
        compare_field("woken_valid", 8'(exp_res.woken_valid), 8'(out_item.woken_valid));
        compare_field("woken_thread", exp_res.woken_thread, out_item.woken_thread);
      end
    end
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Everything but init is refused until the mutex is set up.
  task automatic test_before_init();
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd5, 7'd10));
    issue(make_req(pmw_pkg::ACT_UNLOCK, 8'd5, 7'd10));
    issue(make_req(ACT_RESERVED, 8'd0, 7'd0));
  endtask

  // Init works once; the unused action code reads as not-owner afterwards.
  task automatic test_init_once();
    issue(make_req(pmw_pkg::ACT_INIT, 8'd0, 7'd0));
    issue(make_req(pmw_pkg::ACT_INIT, 8'd255, 7'd127));
    issue(make_req(ACT_RESERVED, 8'd255, 7'd127));
  endtask

  // Unlock while free, grant, relock by the owner, unlock by a stranger.
  task automatic test_grant_and_errors();
    issue(make_req(pmw_pkg::ACT_UNLOCK, 8'd9, 7'd0));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd0, 7'd0));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd0, 7'd50));
    issue(make_req(pmw_pkg::ACT_UNLOCK, 8'd255, 7'd0));
  endtask

  // Fill all seven slots: nice extremes, a tie, a repeat by a queued thread,
  // then one more lock that finds the table full.
  task automatic test_wait_table_fill();
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd255, 7'd127));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd1, 7'd99));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd2, 7'd5));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd3, 7'd5));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd4, 7'd0));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd1, 7'd5));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd128, 7'd64));
    issue(make_req(pmw_pkg::ACT_LOCK, 8'd200, 7'd1));
  endtask

  // Drain by handing off from owner to owner, then release to free.
  task automatic test_priority_handoff();
    repeat (WAIT_SLOTS + 1) issue(make_req(pmw_pkg::ACT_UNLOCK, mx_owner, 7'd0));
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: bursts that lean toward filling the table or toward
  // draining it by owner unlocks, with some noise in every burst.
  // ---------------------------------------------------------------------------
  function automatic logic [TID_W-1:0] pick_thread();
    if ($urandom_range(0, 9) < 7) return TID_W'($urandom_range(1, 12));
    return TID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [NICE_W-1:0] pick_nice();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return NICE_W'($urandom_range(0, 3));     // many ties
    if (roll < 85) return NICE_W'($urandom_range(0, 99));
    return NICE_W'($urandom_range(100, 127));                // out of the nominal range
  endfunction

  function automatic pmw_pkg::pmw_in_t draw_request(bit fill_bias);
    int roll;
    int lock_cut;
    int unlock_cut;
    roll       = $urandom_range(0, 99);
    lock_cut   = fill_bias ? 70 : 20;
    unlock_cut = fill_bias ? 85 : 85;
    if (roll < lock_cut) begin
      // now and then the owner asks again
      if (mx_held && $urandom_range(0, 19) == 0)
        return make_req(pmw_pkg::ACT_LOCK, mx_owner, pick_nice());
      return make_req(pmw_pkg::ACT_LOCK, pick_thread(), pick_nice());
    end
    if (roll < unlock_cut)
      return make_req(pmw_pkg::ACT_UNLOCK, mx_held ? mx_owner : pick_thread(), pick_nice());
    if (roll < 90) return make_req(pmw_pkg::ACT_UNLOCK, pick_thread(), pick_nice());
    if (roll < 95) return make_req(pmw_pkg::ACT_INIT, pick_thread(), pick_nice());
    return make_req(ACT_RESERVED, pick_thread(), pick_nice());
  endfunction

  task automatic test_random_traffic();
    int burst;
    bit fill_bias;
    while (issued < TOTAL_ITEMS) begin
      burst     = $urandom_range(16, 64);
      fill_bias = $urandom_range(0, 1);
      tight     = ($urandom_range(0, 3) == 0);
      repeat (burst) if (issued < TOTAL_ITEMS) issue(draw_request(fill_bias));
    end
    tight = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mx_init  = 1'b0;
    mx_held  = 1'b0;
    mx_owner = '0;
    for (int i = 0; i < WAIT_SLOTS; i++) wq_valid[i] = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_init();
    test_init_once();
    test_grant_and_errors();
    test_wait_table_fill();
    test_priority_handoff();
    test_random_traffic();

    start <= 1'b0;
    // the watchdog bounds this wait
    while (expected_results.size() != 0) @(posedge clk);
    repeat (WAIT_SLOTS + 4) @(posedge clk);

    if (expected_results.size() != 0) begin
      fail_count++;
      $error("%0d result transactions never arrived", expected_results.size());
    end
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
